// ===== rtl/core/fmpc_pkg.sv =====
// shared types and constants of the first-match packet rule classifier
package fmpc_pkg;

  // item codes
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // rule action that counts and keeps scanning
  localparam logic [2:0] ACT_COUNT = 3'd0;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_ACTION = 2'd1;

  localparam logic [15:0] PORT_ANY_HI = 16'hFFFF;
  localparam logic [3:0]  IPV4        = 4'd4;

  // input word
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  rule_index;
    logic [1:0]  word_select;
    logic [63:0] rule_word;
    logic [7:0]  l3_proto;
    logic [3:0]  ip_ver;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [11:0] outer_vid;
    logic [23:0] tunnel_vni;
    logic        has_l4;
    logic [31:0] l4_ports;
  } req_t;

  // result word
  typedef struct packed {
    logic [2:0]  result_action;
    logic [4:0]  matched_id;
    logic [63:0] hit_count;
    logic [63:0] default_count;
  } rsp_t;

  // one rule as read from the table
  typedef struct packed {
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } rule_t;

  // address words w0 and w1
  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] addr;
  } addr_word_t;

  // port range word w2
  typedef struct packed {
    logic [15:0] dst_port_max;
    logic [15:0] dst_port_min;
    logic [15:0] src_port_max;
    logic [15:0] src_port_min;
  } port_word_t;

  // header word w3
  typedef struct packed {
    logic [8:0]  unused;
    logic [2:0]  action;
    logic        any_vni;
    logic        any_vlan;
    logic        any_ver;
    logic        any_proto;
    logic [3:0]  ver;
    logic [7:0]  proto;
    logic [11:0] vlan;
    logic [23:0] vni;
  } hdr_word_t;

  // match unit answer
  typedef struct packed {
    logic       hit;
    logic [2:0] action;
  } match_t;

endpackage

// ===== rtl/core/fmpc_ram.sv =====
// generic single write port ram with registered read
module fmpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/fmpc_match.sv =====
// rule compare unit: one rule against one packet
module fmpc_match (
  input  fmpc_pkg::rule_t  rule,
  input  fmpc_pkg::req_t   pkt,
  output fmpc_pkg::match_t m
);
  import fmpc_pkg::*;

  addr_word_t src_w;
  addr_word_t dst_w;
  port_word_t port_w;
  hdr_word_t  hdr_w;
  logic [15:0] sport;
  logic [15:0] dport;
  logic proto_ok, ver_ok, vlan_ok, vni_ok, src_ok, dst_ok, ports_any, port_ok;

  assign src_w  = addr_word_t'(rule.w0);
  assign dst_w  = addr_word_t'(rule.w1);
  assign port_w = port_word_t'(rule.w2);
  assign hdr_w  = hdr_word_t'(rule.w3);
  assign sport  = pkt.l4_ports[31:16];
  assign dport  = pkt.l4_ports[15:0];

  // exact fields, each with its wildcard
  assign proto_ok = hdr_w.any_proto || (hdr_w.proto == pkt.l3_proto);
  assign ver_ok   = hdr_w.any_ver   || (hdr_w.ver == pkt.ip_ver);
  assign vlan_ok  = hdr_w.any_vlan  || (hdr_w.vlan == pkt.outer_vid);
  assign vni_ok   = hdr_w.any_vni   || (hdr_w.vni == pkt.tunnel_vni);

  // masked addresses, a nonzero mask needs ipv4
  assign src_ok = (src_w.mask == '0) ||
                  ((pkt.ip_ver == IPV4) && (((pkt.ip_src ^ src_w.addr) & src_w.mask) == '0));
  assign dst_ok = (dst_w.mask == '0) ||
                  ((pkt.ip_ver == IPV4) && (((pkt.ip_dst ^ dst_w.addr) & dst_w.mask) == '0));

  // port ranges, a specific range needs an l4 header
  assign ports_any = (port_w.src_port_min == '0) && (port_w.src_port_max == PORT_ANY_HI) &&
                     (port_w.dst_port_min == '0) && (port_w.dst_port_max == PORT_ANY_HI);
  assign port_ok = ports_any ||
                   (pkt.has_l4 &&
                    (sport >= port_w.src_port_min) && (sport <= port_w.src_port_max) &&
                    (dport >= port_w.dst_port_min) && (dport <= port_w.dst_port_max));

  assign m.hit    = proto_ok && ver_ok && src_ok && dst_ok && vlan_ok && vni_ok && port_ok;
  assign m.action = hdr_w.action;
endmodule

// ===== rtl/core/first_match_packet_rule_classifier.sv =====
// first-match packet rule classifier: sequencer, rule table, hit counters
//
//   channel  | direction | handshake                  | word
//   req      | in        | req_valid / req_stall      | fmpc_pkg::req_t
//   rsp      | out       | rsp_valid / rsp_stall      | fmpc_pkg::rsp_t
//   cfg      | in        | cfg_we (no wait)           | cfg_index, cfg_data
//
// a classify word scans up to min(rule_count, RULES) rules before the result
// register: one rule per cycle through the shared compare unit and the table
// read port, the hit counter updated in the same cycle; a terminal match ends
// the scan early, and an empty rule set goes straight to the result state.
// write and unused codes go straight to the result state, a counter read via ST_READ.
// after reset a clearing pass zeroes the hit counters one at a time,
// during which req_stall is high.
// a finished word waits in the output register while rsp_stall is high; a new
// word is taken meanwhile, but its result waits for the register to free up.
module first_match_packet_rule_classifier #(
  parameter int RULES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fmpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  fmpc_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output fmpc_pkg::rsp_t                      rsp
);
  import fmpc_pkg::*;

  localparam int RW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int NW = $clog2(RULES + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]    state;
  req_t          item;
  logic          idx_ok;
  logic [NW-1:0] issue;
  logic          eval_valid;
  logic [RW-1:0] eval_idx;
  logic [2:0]    res_action;
  logic [4:0]    res_id;
  logic [63:0]   res_hits;
  logic [63:0]   default_cnt;
  logic [4:0]    rule_count;
  logic [2:0]    miss_action;

  logic          accept;
  logic          req_idx_ok;
  logic [NW-1:0] n_lim;
  logic          scan_issue;
  logic          cand;
  logic          terminal;
  logic          rsp_free;

  logic          tbl_we;
  logic [63:0]   tbl_rd [4];
  rule_t         rule;
  match_t        m;

  logic          cnt_we;
  logic [RW-1:0] cnt_waddr;
  logic [63:0]   cnt_wdata;
  logic [RW-1:0] cnt_raddr;
  logic [63:0]   cnt_rdata;

  // handshake and scan limits
  assign req_stall  = (state != ST_IDLE);
  assign accept     = req_valid && !req_stall;
  assign req_idx_ok = (32'(req.rule_index) < RULES);
  assign n_lim      = (32'(rule_count) > RULES) ? NW'(RULES) : NW'(rule_count);
  assign scan_issue = (issue < n_lim);
  assign rsp_free   = !rsp_valid || !rsp_stall;

  // rule table: one ram per rule word, all read at the scan index
  assign tbl_we = accept && (req.action == OP_WRITE) && req_idx_ok;

  for (genvar g = 0; g < 4; g++) begin : g_word
    fmpc_ram #(.WIDTH(64), .DEPTH(RULES)) u_word (
      .clk   (clk),
      .we    (tbl_we && (req.word_select == 2'(g))),
      .waddr (RW'(req.rule_index)),
      .wdata (req.rule_word),
      .raddr (issue[RW-1:0]),
      .rdata (tbl_rd[g])
    );
  end

  assign rule = '{w3: tbl_rd[3], w2: tbl_rd[2], w1: tbl_rd[1], w0: tbl_rd[0]};

  // shared compare unit on the rule read last cycle
  fmpc_match u_match (
    .rule (rule),
    .pkt  (item),
    .m    (m)
  );

  assign cand     = (state == ST_SCAN) && eval_valid && m.hit;
  assign terminal = cand && (m.action != ACT_COUNT);

  // hit counters: cleared after reset, incremented on every matching rule
  assign cnt_raddr = (state == ST_IDLE) ? RW'(req.rule_index) : issue[RW-1:0];
  assign cnt_we    = (state == ST_CLEAR) || cand;
  assign cnt_waddr = (state == ST_CLEAR) ? issue[RW-1:0] : eval_idx;
  assign cnt_wdata = (state == ST_CLEAR) ? 64'd0 : (cnt_rdata + 64'd1);

  fmpc_ram #(.WIDTH(64), .DEPTH(RULES)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      issue       <= '0;
      eval_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
      default_cnt <= '0;
      rule_count  <= '0;
      miss_action <= 3'd1;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RULE_COUNT:  rule_count <= cfg_data;
          CFG_MISS_ACTION: miss_action <= cfg_data[2:0];
          default: ;
        endcase
      end

      // output register
      if ((state == ST_RESULT) && rsp_free) begin
        rsp_valid         <= 1'b1;
        rsp.result_action <= res_action;
        rsp.matched_id    <= res_id;
        rsp.hit_count     <= res_hits;
        rsp.default_count <= default_cnt;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (issue == NW'(RULES - 1)) begin
            issue <= '0;
            state <= ST_IDLE;
          end else begin
            issue <= issue + NW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item       <= req;
            idx_ok     <= req_idx_ok;
            res_id     <= '0;
            res_hits   <= '0;
            issue      <= '0;
            eval_valid <= 1'b0;
            case (req.action)
              OP_CLASSIFY: begin
                if (n_lim == '0) begin
                  default_cnt <= default_cnt + 64'd1;
                  res_action  <= miss_action;
                  state       <= ST_RESULT;
                end else begin
                  res_action <= ACT_COUNT;
                  state      <= ST_SCAN;
                end
              end
              OP_READ: begin
                res_action <= ACT_COUNT;
                state      <= ST_READ;
              end
              default: begin
                res_action <= ACT_COUNT;
                state      <= ST_RESULT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // issue the next rule while the previous one is compared
          issue      <= issue + NW'(scan_issue);
          eval_valid <= scan_issue;
          eval_idx   <= issue[RW-1:0];
          if (terminal) begin
            res_action <= m.action;
            res_id     <= 5'({1'b0, eval_idx} + 1'b1);
            res_hits   <= cnt_rdata + 64'd1;
            state      <= ST_RESULT;
          end else if (!scan_issue) begin
            // last rule compared, no terminal match
            default_cnt <= default_cnt + 64'd1;
            res_action  <= miss_action;
            state       <= ST_RESULT;
          end
        end
        ST_READ: begin
          res_hits <= idx_ok ? cnt_rdata : 64'd0;
          state    <= ST_RESULT;
        end
        ST_RESULT: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan index never passes the rule limit
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue <= n_lim))
    else $error("scan index beyond rule limit");

  // a compared rule is always one in use
  a_eval_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && eval_valid) |-> (NW'(eval_idx) < n_lim))
    else $error("compared rule outside the rules in use");

  // default counter only steps by one
  a_default_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (default_cnt != $past(default_cnt))) |->
    (default_cnt == $past(default_cnt) + 64'd1))
    else $error("default counter jumped");

  // a taken result is not shown again without a new load
  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && (state != ST_RESULT)) |=> !rsp_valid)
    else $error("result word repeated");

  // nothing comes out during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !rsp_valid)
    else $error("result word during counter clear");
endmodule
